// File: rtl/sql_like_pattern_matcher_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the pattern matcher RTL.
// Both macros sample on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SQL_LIKE_PATTERN_MATCHER_TOP_ASSERT_SVH
`define SQL_LIKE_PATTERN_MATCHER_TOP_ASSERT_SVH

// Property checked every clock edge outside reset.
`define SLPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked every clock edge outside reset.
`define SLPM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/slpm_pkg.sv
// ---------------------------------------------------------------------------
// slpm_pkg
// Shared constants, types and helpers of the SQL LIKE pattern matcher.
// ---------------------------------------------------------------------------
package slpm_pkg;

  localparam int MAX_PATTERN_DEF = 32;

  localparam logic [7:0] ANY_RUN = 8'h25;  // '%'
  localparam logic [7:0] ANY_ONE = 8'h5F;  // '_'

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TEXT   = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  typedef struct packed {
    logic       go;
    logic [1:0] kind;
    logic [7:0] char_byte;
  } op_t;

  typedef struct packed {
    logic matched;
    logic pattern_error;
  } res_t;

  // a-z folded to A-Z
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// File: rtl/slpm_cmd_if.sv
// ---------------------------------------------------------------------------
// slpm_cmd_if
// Command channel: pattern load, text bytes and end of text.
// ---------------------------------------------------------------------------
interface slpm_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink (input valid, input kind, input char_byte, output ready);
endinterface

// File: rtl/slpm_res_if.sv
// ---------------------------------------------------------------------------
// slpm_res_if
// Result channel: one item per end of text.
// ---------------------------------------------------------------------------
interface slpm_res_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_error;

  modport source (output valid, output matched, output pattern_error, input ready);
  modport sink (input valid, input matched, input pattern_error, output ready);
endinterface

// File: rtl/sql_like_pattern_matcher_top.sv
// ---------------------------------------------------------------------------
// sql_like_pattern_matcher_top
// SQL LIKE / ILIKE matcher with a loadable pattern and streamed text bytes.
// ---------------------------------------------------------------------------
//   channel  dir  fields                      items
//   cmd      in   kind, char_byte             clear, append, text, end
//   res      out  matched, pattern_error      one per end-of-text item
//   cfg      in   cfg_we, cfg_wdata           case_fold register
//
// One item per cycle unless cmd stalls; an item is registered, then processed.
// An end-of-text result passes the command stage and the output register to res.
// The single command stage and one output register decouple the two sides;
// cmd stalls only when an end item waits on a full, unread output register.
// rst (synchronous) empties the pattern and clears case_fold; no clearing pass.
// ---------------------------------------------------------------------------
`include "sql_like_pattern_matcher_top_assert.svh"

module sql_like_pattern_matcher_top #(
  parameter int MAX_PATTERN = slpm_pkg::MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  slpm_cmd_if.sink          cmd,
  slpm_res_if.source        res
);
  import slpm_pkg::*;

  logic       case_fold;
  logic       s1_valid;
  logic [1:0] s1_kind;
  logic [7:0] s1_byte;
  logic       s1_go;
  logic       out_free;
  logic       res_valid;
  res_t       res_q;
  res_t       rslt;
  op_t        op;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_fold <= 1'b0;
    end else if (cfg_we) begin
      case_fold <= cfg_wdata;
    end
  end

  assign out_free  = !res_valid || res.ready;
  assign s1_go     = s1_valid && (s1_kind != KIND_END || out_free);
  assign cmd.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_kind <= cmd.kind;
      s1_byte <= cmd.char_byte;
    end
  end

  assign op.go        = s1_go;
  assign op.kind      = s1_kind;
  assign op.char_byte = s1_byte;

  slpm_engine #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .case_fold (case_fold),
    .op        (op),
    .rslt      (rslt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go && s1_kind == KIND_END) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_kind == KIND_END) begin
      res_q <= rslt;
    end
  end

  assign res.valid         = res_valid;
  assign res.matched       = res_q.matched;
  assign res.pattern_error = res_q.pattern_error;

  `SLPM_ASSERT_IMP(a_end_loads, s1_go && s1_kind == KIND_END, ##1 res_valid,
                   "end item did not load a result")
  `SLPM_ASSERT_IMP(a_err_nomatch, res_valid && res_q.pattern_error, !res_q.matched,
                   "match reported on overflowed pattern")
  `SLPM_ASSERT_IMP(a_stall_cause, !cmd.ready,
                   s1_valid && s1_kind == KIND_END && res_valid && !res.ready,
                   "command stage stalled without a blocked result")
  `SLPM_ASSERT_IMP(a_s1_hold, s1_valid && !s1_go, ##1 s1_valid && $stable(s1_kind),
                   "stalled command item lost")

endmodule

// File: rtl/slpm_engine.sv
// ---------------------------------------------------------------------------
// slpm_engine
// Pattern store and bit-parallel active position set. One op per cycle.
// ---------------------------------------------------------------------------
`include "sql_like_pattern_matcher_top_assert.svh"

module slpm_engine #(
  parameter int MAX_PATTERN = slpm_pkg::MAX_PATTERN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          case_fold,
  input  slpm_pkg::op_t op,
  output slpm_pkg::res_t rslt
);
  import slpm_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LVL   = $clog2(MAX_PATTERN + 1);
  localparam logic [MAX_PATTERN:0] RESTART = (MAX_PATTERN + 1)'(1);

  logic [7:0]       store [MAX_PATTERN];
  logic [CNT_W-1:0] count;
  logic             ovf;
  // active set kept unclosed; closure over '%' is applied on read
  logic [MAX_PATTERN:0] raw;

  logic                   full;
  logic [7:0]             cfold;
  logic [MAX_PATTERN-1:0] used;
  logic [MAX_PATTERN-1:0] pct;
  logic [MAX_PATTERN-1:0] hit;
  logic [LVL:0][MAX_PATTERN:0] g;
  logic [LVL:0][MAX_PATTERN:0] pm;
  logic [MAX_PATTERN:0]   closed;
  logic [MAX_PATTERN:0]   adv;

  assign full  = (count == CNT_W'(MAX_PATTERN));
  assign cfold = fold_char(op.char_byte);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      used[i] = CNT_W'(i) < count;
      pct[i]  = used[i] && (store[i] == ANY_RUN);
      hit[i]  = used[i] && (store[i] != ANY_RUN) &&
                ((store[i] == ANY_ONE) ||
                 (case_fold ? (fold_char(store[i]) == cfold) : (store[i] == op.char_byte)));
    end
  end

  // Prefix closure: bit j+1 picks up bit j wherever position j holds '%'
  always_comb begin
    g[0]  = raw;
    pm[0] = {pct, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j <= MAX_PATTERN; j++) begin
        if (j >= (1 << l)) begin
          g[l+1][j]  = g[l][j] | (pm[l][j] & g[l][j - (1 << l)]);
          pm[l+1][j] = pm[l][j] & pm[l][j - (1 << l)];
        end else begin
          g[l+1][j]  = g[l][j];
          pm[l+1][j] = pm[l][j];
        end
      end
    end
    closed = g[LVL];
  end

  always_comb begin
    adv = '0;
    adv[MAX_PATTERN-1:0] = closed[MAX_PATTERN-1:0] & pct;
    adv[MAX_PATTERN:1]   = adv[MAX_PATTERN:1] | (closed[MAX_PATTERN-1:0] & hit);
  end

  assign rslt.matched       = !ovf && closed[count];
  assign rslt.pattern_error = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      raw   <= RESTART;
    end else if (op.go) begin
      unique case (op.kind)
        KIND_CLEAR: begin
          count <= '0;
          ovf   <= 1'b0;
          raw   <= RESTART;
        end
        KIND_APPEND: begin
          if (!full) begin
            count <= count + CNT_W'(1);
          end else begin
            ovf <= 1'b1;
          end
          raw <= RESTART;
        end
        KIND_TEXT: begin
          raw <= adv;
        end
        default: begin
          raw <= RESTART;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op.go && op.kind == KIND_APPEND && !full) begin
      store[count[IDX_W-1:0]] <= op.char_byte;
    end
  end

  `SLPM_ASSERT(a_count_range, count <= CNT_W'(MAX_PATTERN), "pattern count past store depth")
  `SLPM_ASSERT_IMP(a_ovf_full, ovf, full, "overflow flagged with room in store")
  `SLPM_ASSERT_IMP(a_restart, op.go && op.kind != KIND_TEXT, ##1 raw == RESTART,
                   "active set not restarted")

endmodule
